// ----- rtl/core/stirling_second_kind_engine_defines.svh -----
// Assertion macros for the Stirling number engine.
// Included by the RTL files that carry concurrent assertions.
`ifndef STIRLING_SECOND_KIND_ENGINE_DEFINES_SVH
`define STIRLING_SECOND_KIND_ENGINE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define SSE_ASSERT(label, clk, rst, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst)) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define SSE_ASSERT_NEVER(label, clk, rst, cond, msg) \
    `SSE_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ----- rtl/core/sse_pkg.sv -----
// Shared types and constants for the Stirling number engine.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package sse_pkg;

    localparam int NUM_W     = 6;   // width of count_n and parts_k
    localparam int WORD_W    = 64;  // result word width
    localparam int CNT_W     = 7;   // row and step counters, wide enough for 64
    localparam int N_MAX_DEF = 63;  // default largest count_n the row buffer holds

    typedef logic [WORD_W-1:0] word_t;

    // One row entry: saturating value plus its saturation mark.
    typedef struct packed {
        logic  sat;
        word_t value;
    } row_entry_t;

    // Control of the shared multiply-add unit.
    typedef struct packed {
        logic step;      // load the multiply stage
        logic first;     // multiplicand is the fresh zero entry of a new row
        logic acc_mode;  // adder sums the running total and the read entry
    } alu_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sse_if.sv -----
// Valid/ready channel interfaces for the Stirling number engine.
// Depends on sse_pkg for field widths.
`default_nettype none

interface sse_item_if import sse_pkg::*;;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] count_n;
    logic [NUM_W-1:0] parts_k;

    modport source (output valid, output count_n, output parts_k, input ready);
    modport sink   (input valid, input count_n, input parts_k, output ready);
endinterface

interface sse_result_if import sse_pkg::*;;
    logic  valid;
    logic  ready;
    word_t stirling_value;
    word_t partition_total;
    logic  overflow;

    modport source (output valid, output stirling_value, output partition_total,
                    output overflow, input ready);
    modport sink   (input valid, input stirling_value, input partition_total,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sse_row_mem.sv -----
// Scratch row buffer: one write port, one read port with registered data.
// Depends on sse_pkg for the entry type.
`default_nettype none

module sse_row_mem import sse_pkg::*; #(
    parameter int DEPTH = N_MAX_DEF + 1,
    parameter int AW    = $clog2(N_MAX_DEF + 1)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  row_entry_t    wdata,
    input  logic [AW-1:0] raddr,
    output row_entry_t    rdata
);

    row_entry_t mem [DEPTH];
    row_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sse_alu.sv -----
// Shared saturating multiply-add unit: registered k*S multiply, then add.
// Depends on sse_pkg for the entry and control types.
`default_nettype none

module sse_alu import sse_pkg::*; (
    input  logic             clk,
    input  alu_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] mul_k,
    input  row_entry_t       add_b,
    input  row_entry_t       acc_a,
    output row_entry_t       sum
);

    localparam int PW = WORD_W + NUM_W;

    row_entry_t    prod_reg;
    row_entry_t    addend_reg;
    row_entry_t    prod_next;
    word_t         mul_a;
    logic          mul_a_sat;
    logic [PW-1:0] prod_full;
    row_entry_t    add_x;
    row_entry_t    add_y;
    logic [WORD_W:0] sum_full;

    // The previous addend is the old entry one column up, the next multiplicand.
    always_comb
    begin
        mul_a     = ctrl.first ? '0 : addend_reg.value;
        mul_a_sat = ctrl.first ? 1'b0 : addend_reg.sat;
        prod_full = PW'(mul_a) * PW'(mul_k);
        if (mul_k == '0)
        begin
            prod_next = '0;
        end
        else if (mul_a_sat || (prod_full[PW-1:WORD_W] != '0))
        begin
            prod_next.sat   = 1'b1;
            prod_next.value = '1;
        end
        else
        begin
            prod_next.sat   = 1'b0;
            prod_next.value = prod_full[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            prod_reg   <= prod_next;
            addend_reg <= add_b;
        end
    end

    always_comb
    begin
        add_x    = ctrl.acc_mode ? acc_a : prod_reg;
        add_y    = ctrl.acc_mode ? add_b : addend_reg;
        sum_full = {1'b0, add_x.value} + {1'b0, add_y.value};
        if (add_x.sat || add_y.sat || sum_full[WORD_W])
        begin
            sum.sat   = 1'b1;
            sum.value = '1;
        end
        else
        begin
            sum.sat   = 1'b0;
            sum.value = sum_full[WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stirling_second_kind_engine.sv -----
// Stirling number engine, S(n,k) and the sum of S(n,i), one item at a time.
// For 1 <= n <= N_MAX the rows are built and summed on the single multiply-add unit.
// n = 0 or n above N_MAX skips the row and sum states and goes straight to done.
// The next item is taken once the result has loaded into the output registers.
// Async active-low reset clears control; the row buffer is not cleared.
`default_nettype none
`include "stirling_second_kind_engine_defines.svh"

module stirling_second_kind_engine import sse_pkg::*; #(
    parameter int N_MAX = N_MAX_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sse_item_if.sink     item,
    sse_result_if.source result
);

    localparam int DEPTH = N_MAX + 1;
    localparam int AW    = $clog2(N_MAX + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROW  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] c_reg, c_next;
    logic             out_valid_reg, out_valid_next;

    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] k_reg, k_next;
    row_entry_t       res_reg, res_next;
    row_entry_t       total_reg, total_next;
    word_t            out_val_reg, out_val_next;
    word_t            out_tot_reg, out_tot_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [CNT_W-1:0] n_ext;
    logic [CNT_W-1:0] k_ext;
    logic [CNT_W-1:0] j_a;
    logic [CNT_W-1:0] wj;
    logic [CNT_W-1:0] rj;
    logic             stage_a;
    logic             stage_b;
    logic             rd_active;
    logic             load_out;

    alu_ctrl_t        alu_ctrl;
    logic [NUM_W-1:0] mul_k;
    row_entry_t       add_b;
    row_entry_t       seed;
    row_entry_t       alu_sum;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    row_entry_t       rd_entry;

    sse_alu u_alu (
        .clk   (clk),
        .ctrl  (alu_ctrl),
        .mul_k (mul_k),
        .add_b (add_b),
        .acc_a (total_reg),
        .sum   (alu_sum)
    );

    sse_row_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (alu_sum),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    // Row r runs steps c = 0..r+1: read column r-1-c, multiply column r-c+1,
    // write column r-c+2. Column 0 is never stored; it is 1 only in row 0, read while row 1 is built.
    always_comb
    begin
        n_ext   = CNT_W'(n_reg);
        k_ext   = CNT_W'(k_reg);
        j_a     = r_reg - c_reg + CNT_W'(1);
        wj      = r_reg - c_reg + CNT_W'(2);
        stage_a = (state_reg == ST_ROW) && (c_reg != '0) && (c_reg <= r_reg);
        stage_b = (state_reg == ST_ROW) && (c_reg >= CNT_W'(2));

        seed.sat   = 1'b0;
        seed.value = (r_reg == CNT_W'(1)) ? WORD_W'(1) : '0;

        alu_ctrl.step     = stage_a;
        alu_ctrl.first    = (c_reg == CNT_W'(1));
        alu_ctrl.acc_mode = (state_reg == ST_SUM);
        mul_k             = NUM_W'(j_a);
        add_b             = ((state_reg == ST_ROW) && (j_a == CNT_W'(1))) ? seed : rd_entry;

        mem_we    = stage_b;
        mem_waddr = AW'(wj);

        if (state_reg == ST_ROW)
        begin
            rj        = r_reg - c_reg - CNT_W'(1);
            rd_active = (c_reg + CNT_W'(2)) <= r_reg;
        end
        else
        begin
            rj        = c_reg + CNT_W'(1);
            rd_active = (state_reg == ST_SUM) && (rj <= n_ext);
        end
        mem_raddr = rd_active ? AW'(rj) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        total_next     = total_reg;
        out_val_next   = out_val_reg;
        out_tot_next   = out_tot_reg;
        out_ovf_next   = out_ovf_reg;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    n_next     = item.count_n;
                    k_next     = item.parts_k;
                    res_next   = '0;
                    total_next = '0;
                    r_next     = CNT_W'(1);
                    c_next     = '0;
                    if (int'(item.count_n) > N_MAX)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (item.count_n == '0)
                    begin
                        res_next.value = (item.parts_k == '0) ? WORD_W'(1) : '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                if (c_reg == (r_reg + CNT_W'(1)))
                begin
                    c_next = '0;
                    if (r_reg == n_ext)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        r_next = r_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    c_next = c_reg + CNT_W'(1);
                end
            end
            ST_SUM:
            begin
                // Step c adds column c; k = 0 or k above n keeps the zero value.
                if (c_reg == '0)
                begin
                    total_next = '0;
                    res_next   = '0;
                    c_next     = CNT_W'(1);
                end
                else
                begin
                    total_next = alu_sum;
                    if (c_reg == k_ext)
                    begin
                        res_next = rd_entry;
                    end
                    if (c_reg == n_ext)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        c_next = c_reg + CNT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out     = 1'b1;
                    out_val_next = res_reg.value;
                    out_tot_next = total_reg.value;
                    out_ovf_next = res_reg.sat || total_reg.sat;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        total_reg   <= total_next;
        out_val_reg <= out_val_next;
        out_tot_reg <= out_tot_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign item.ready             = (state_reg == ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.stirling_value  = out_val_reg;
    assign result.partition_total = out_tot_reg;
    assign result.overflow        = out_ovf_reg;

    `SSE_ASSERT(a_row_bounds, clk, rst_n,
        (state_reg == ST_ROW) |-> ((r_reg != '0) && (r_reg <= n_ext) &&
                                   (c_reg <= (r_reg + CNT_W'(1)))),
        "row or step counter out of range")
    `SSE_ASSERT(a_accept_busy, clk, rst_n,
        (item.valid && item.ready) |=> (state_reg != ST_IDLE),
        "sequencer stayed idle after an input transfer")
    `SSE_ASSERT(a_out_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE),
        "result raised without a finished item")
    `SSE_ASSERT(a_total_sat_ones, clk, rst_n,
        ((state_reg == ST_DONE) && total_reg.sat) |-> (total_reg.value == '1),
        "saturated total is not all ones")
    `SSE_ASSERT(a_write_column, clk, rst_n,
        mem_we |-> ((wj != '0) && (wj <= n_ext)),
        "row write outside columns one to n")
    `SSE_ASSERT_NEVER(a_no_rd_wr_clash, clk, rst_n,
        mem_we && rd_active && (mem_waddr == mem_raddr),
        "row buffer read and write hit the same column")

endmodule

`default_nettype wire
